// File: rtl/lfo_pkg.sv
// Package for the LFO modulation source: payload types, register indexes,
// waveform codes and the quarter-wave sine table.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package lfo_pkg;

	// Sizes fixed by the phase accumulator and the sine table.
	localparam int SINE_TABLE_BITS = 8;
	localparam int PHASE_BITS      = 32;
	localparam int SINE_N          = 1 << SINE_TABLE_BITS;
	localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;

	// Field widths.
	localparam int STEP_W    = 26;
	localparam int ELAPSED_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 26;
	localparam int LEVEL_W   = 14;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MODE  = 3'd5;

	// Waveform codes.
	localparam logic [1:0] WAVE_SINE     = 2'd0;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [1:0] WAVE_SAW      = 2'd3;

	// MIDI status bytes.
	localparam logic [7:0] STATUS_CC   = 8'hB0;
	localparam logic [7:0] STATUS_BEND = 8'hE0;

	// Reset values of the registers and the level state.
	localparam logic [STEP_W-1:0]  STEP_RESET  = 26'd4294967;
	localparam logic [6:0]         DEPTH_RESET = 7'd64;
	localparam logic [6:0]         CC_RESET    = 7'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 14'd64;

	// One input item and one result item.
	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic                 restart;
		logic                 link_up;
	} tick_t;

	typedef struct packed {
		logic [7:0]         status_byte;
		logic [6:0]         data_first;
		logic [6:0]         data_second;
		logic [LEVEL_W-1:0] level;
	} msg_t;

	// Quarter-wave sine table; the peak at the end of the quarter is supplied by the top level.
	typedef logic [SINE_N-1:0][14:0] sine_lut_t;

	// Polynomial approximation of one quarter of a sine, evaluated at elaboration.
	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		for (int k = 0; k < SINE_N; k++) begin
			x  = longint'(k) << (16 - SINE_TABLE_BITS);
			x2 = (x * x) >> 16;
			t  = (64'd4725 * x2) >> 16;
			t  = 64'd42107 - t;
			t  = (t * x2) >> 16;
			t  = 64'd102918 - t;
			s  = (t * x) >> 16;
			v  = (s * 64'd32767 + 64'd32768) >> 16;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			lut[k] = v[14:0];
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

// File: rtl/lfo_midi_modulation_source_top.sv
// LFO modulation source top level: phase accumulator, waveform shaping, level
// scaling and MIDI message generation. Depends on lfo_pkg.
`default_nettype none

// Each accepted tick is taken in a transfer, then runs through four steps of a
// small sequencer around one shared 27 x 17 signed multiplier, which first forms
// phase_step * elapsed_ms for the phase accumulator and later scales the
// waveform sample by depth. The tick channel stalls during those steps. At most
// one message results per tick; it sits in an output register, so a new tick is
// taken while it waits, and that tick holds in its last step until the message
// has been transferred. While run_enable is low a tick is taken and changes
// nothing. There is no clearing pass after reset.
module lfo_midi_modulation_source_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       tick_valid,
	output logic                            tick_stall,
	input  wire lfo_pkg::tick_t             tick,
	output logic                            msg_valid,
	input  wire logic                       msg_stall,
	output lfo_pkg::msg_t                   msg,
	input  wire logic                       cfg_we,
	input  wire logic [lfo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lfo_pkg::CFG_W-1:0]  cfg_data
);
	import lfo_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_WAVE,
		S_SCALE,
		S_LEVEL
	} state_t;

	state_t                   state_q;
	logic                     run_enable_q;
	logic [1:0]               wave_select_q;
	logic [STEP_W-1:0]        phase_step_q;
	logic [6:0]               depth_q;
	logic [6:0]               cc_number_q;
	logic                     pitch_mode_q;

	logic [PHASE_BITS-1:0]    phase_q;
	logic [LEVEL_W-1:0]       last_level_q;
	logic                     restart_q;
	logic                     link_up_q;
	logic signed [43:0]       prod_q;
	logic signed [15:0]       wave_q;
	logic                     msg_valid_q;
	msg_t                     msg_q;

	logic                     tick_xfer;
	logic                     msg_load;
	logic signed [26:0]       mul_a;
	logic signed [16:0]       mul_b;
	logic signed [43:0]       mul_p;
	logic [15:0]              u;
	logic [SINE_TABLE_BITS-1:0] sine_k;
	logic [SINE_IDX_W-1:0]    sine_idx;
	logic [14:0]              sine_mag;
	logic signed [18:0]       two_u;
	logic signed [18:0]       tri_raw;
	logic signed [15:0]       wave_d;
	logic signed [25:0]       scaled;
	logic signed [25:0]       num_bend;
	logic signed [25:0]       num_cc;
	logic [LEVEL_W-1:0]       level_d;

	assign tick_xfer  = tick_valid && !tick_stall;
	assign tick_stall = (state_q != S_IDLE);
	assign msg_valid  = msg_valid_q;
	assign msg        = msg_q;

	// A changed level with the link up loads the output register in the last step.
	assign msg_load = (state_q == S_LEVEL) && (!msg_valid_q || !msg_stall)
		&& (level_d != last_level_q) && link_up_q;

	// Shared multiplier: phase increment while idle, depth scaling later on.
	always_comb begin
		if (state_q == S_IDLE) begin
			mul_a = signed'({1'b0, phase_step_q});
			mul_b = signed'({1'b0, tick.elapsed_ms});
		end else begin
			mul_a = 27'(wave_q);
			mul_b = signed'({10'd0, depth_q});
		end
		mul_p = 44'(mul_a * mul_b);
	end

	// Waveform sample from the top sixteen bits of the phase.
	always_comb begin
		u        = phase_q[PHASE_BITS-1 -: 16];
		sine_k   = u[13 -: SINE_TABLE_BITS];
		sine_idx = u[14] ? (SINE_IDX_W'(SINE_N) - {1'b0, sine_k}) : {1'b0, sine_k};
		sine_mag = sine_idx[SINE_TABLE_BITS] ? 15'd32767
			: SINE_LUT[sine_idx[SINE_TABLE_BITS-1:0]];
		two_u    = signed'({2'b00, u, 1'b0});
		if (u <= 16'd32768) begin
			tri_raw = two_u - 19'sd32768;
		end else begin
			tri_raw = 19'sd98304 - two_u;
		end
		unique case (wave_select_q)
			WAVE_SINE: begin
				wave_d = u[15] ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});
			end
			WAVE_TRIANGLE: begin
				wave_d = (tri_raw > 19'sd32767) ? 16'sd32767 : tri_raw[15:0];
			end
			WAVE_SQUARE: begin
				wave_d = (u <= 16'd32768) ? 16'sd32767 : -16'sd32768;
			end
			WAVE_SAW: begin
				wave_d = signed'({~u[15], u[14:0]});
			end
			default: begin
				wave_d = '0;
			end
		endcase
	end

	// Centre, floor and clamp the scaled sample for the selected message type.
	always_comb begin
		scaled   = signed'(prod_q[25:0]);
		num_bend = 26'sd4194304 + scaled;
		num_cc   = 26'sd4194304 + scaled;
		if (pitch_mode_q) begin
			if (num_bend < 0) begin
				level_d = '0;
			end else if (num_bend[25:9] > 17'd16383) begin
				level_d = 14'd16383;
			end else begin
				level_d = num_bend[22:9];
			end
		end else begin
			if (num_cc < 0) begin
				level_d = '0;
			end else if (num_cc[25:16] > 10'd127) begin
				level_d = 14'd127;
			end else begin
				level_d = {4'd0, num_cc[25:16]};
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q  <= 1'b0;
			wave_select_q <= WAVE_SINE;
			phase_step_q  <= STEP_RESET;
			depth_q       <= DEPTH_RESET;
			cc_number_q   <= CC_RESET;
			pitch_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RUN_ENABLE:  run_enable_q  <= cfg_data[0];
				CFG_WAVE_SELECT: wave_select_q <= cfg_data[1:0];
				CFG_PHASE_STEP:  phase_step_q  <= cfg_data[STEP_W-1:0];
				CFG_DEPTH:       depth_q       <= cfg_data[6:0];
				CFG_CC_NUMBER:   cc_number_q   <= cfg_data[6:0];
				CFG_PITCH_MODE:  pitch_mode_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, oscillator state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= '0;
			last_level_q <= LEVEL_RESET;
			msg_valid_q  <= 1'b0;
		end else begin
			if (msg_load) begin
				msg_valid_q <= 1'b1;
			end else if (msg_valid_q && !msg_stall) begin
				msg_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tick_xfer && run_enable_q) begin
						prod_q    <= mul_p;
						restart_q <= tick.restart;
						link_up_q <= tick.link_up;
						state_q   <= S_ACC;
					end
				end
				S_ACC: begin
					phase_q <= (restart_q ? '0 : phase_q) + prod_q[PHASE_BITS-1:0];
					state_q <= S_WAVE;
				end
				S_WAVE: begin
					wave_q  <= wave_d;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					prod_q  <= mul_p;
					state_q <= S_LEVEL;
				end
				S_LEVEL: begin
					// Hold while an earlier message still waits for its transfer.
					if (!msg_valid_q || !msg_stall) begin
						if (level_d != last_level_q) begin
							last_level_q <= level_d;
							if (link_up_q) begin
								msg_q.level <= level_d;
								if (pitch_mode_q) begin
									msg_q.status_byte <= STATUS_BEND;
									msg_q.data_first  <= level_d[6:0];
									msg_q.data_second <= level_d[13:7];
								end else begin
									msg_q.status_byte <= STATUS_CC;
									msg_q.data_first  <= cc_number_q;
									msg_q.data_second <= level_d[6:0];
								end
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A tick taken while running keeps the tick channel stalled in the next cycle.
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer && run_enable_q |=> tick_stall)
		else $error("tick channel not stalled after a running tick");

	// A tick taken while disabled leaves the phase untouched.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tick_xfer && !run_enable_q |=> $stable(phase_q))
		else $error("phase changed on a disabled tick");

	// A new message carries the level just stored as the last level.
	a_msg_level: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(msg_valid) |-> msg.level == last_level_q)
		else $error("message level differs from stored level");

	// A new message only appears when the level has changed.
	a_msg_changed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(msg_valid) |-> msg.level != $past(last_level_q))
		else $error("message sent for an unchanged level");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for lfo_midi_modulation_source_top: a bit-true predictor of the
// phase accumulator, waveforms and level scaling checks every MIDI message transfer.
// Depends on lfo_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module testbench;
	import lfo_pkg::*;

	// Indexes beyond the register map; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_TICKS  = 1400;
	localparam int TIMEOUT_NS    = 2_000_000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_stall;
	tick_t                tick_in   = '0;
	logic                 msg_valid;
	logic                 msg_stall = 1'b0;
	msg_t                 msg_out;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the registers and the oscillator state.
	logic                 run_on;
	logic [1:0]           wave_sel;
	logic [STEP_W-1:0]    step_reg;
	logic [6:0]           depth_reg;
	logic [6:0]           cc_num;
	logic                 bend_mode;
	logic [31:0]          phase;
	logic [LEVEL_W-1:0]   prev_level;

	msg_t expected_msgs[$];
	int   fail_count    = 0;
	int   burst_left    = 0;
	int   hold_requests = 0;

	always #1 clk = ~clk;

	lfo_midi_modulation_source_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick      (tick_in),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One entry of the quarter-wave table, from the polynomial approximation.
	function automatic int quarter_sine(int unsigned k);
		longint unsigned x, x2, t, s, v;
		if (k >= SINE_N) begin
			return 32767;
		end
		x  = longint'(k) << (16 - SINE_TABLE_BITS);
		x2 = (x * x) >> 16;
		t  = 42107 - ((4725 * x2) >> 16);
		t  = 102918 - ((t * x2) >> 16);
		s  = (t * x) >> 16;
		v  = (s * 32767 + 32768) >> 16;
		return (v > 32767) ? 32767 : int'(v);
	endfunction

	// Signed Q1.15 sample of the selected waveform at phase position u.
	function automatic int wave_value(logic [15:0] u);
		int          uu;
		int unsigned k;
		int          v;
		uu = int'(u);
		k  = (uu >> (14 - SINE_TABLE_BITS)) & (SINE_N - 1);
		case (wave_sel)
			WAVE_SINE: begin
				case (u[15:14])
					2'd0: v = quarter_sine(k);
					2'd1: v = quarter_sine(SINE_N - k);
					2'd2: v = -quarter_sine(k);
					default: v = -quarter_sine(SINE_N - k);
				endcase
			end
			WAVE_TRIANGLE: begin
				v = (uu <= 32768) ? 2 * uu - 32768 : 98304 - 2 * uu;
				if (v > 32767) begin
					v = 32767;
				end
			end
			WAVE_SQUARE: v = (uu <= 32768) ? 32767 : -32768;
			default: v = uu - 32768;
		endcase
		return v;
	endfunction

	// Advances the shadow state by one tick and works out the message it causes, if any.
	function automatic bit predict_tick(input tick_t item, output msg_t m);
		longint unsigned advance;
		longint          num;
		logic [LEVEL_W-1:0] lvl;
		m = '0;
		if (!run_on) begin
			return 1'b0;
		end
		if (item.restart) begin
			phase = '0;
		end
		advance = longint'(step_reg) * longint'(item.elapsed_ms);
		phase   = phase + advance[31:0];
		num     = longint'(wave_value(phase[31:16])) * longint'(depth_reg);
		if (bend_mode) begin
			num = num + 8192 * 512;
			if (num < 0) begin
				num = 0;
			end
			num = num >>> 9;
			lvl = (num > 16383) ? 14'd16383 : num[LEVEL_W-1:0];
		end else begin
			num = num + 64 * 65536;
			if (num < 0) begin
				num = 0;
			end
			num = num >>> 16;
			lvl = (num > 127) ? 14'd127 : num[LEVEL_W-1:0];
		end
		if (lvl == prev_level) begin
			return 1'b0;
		end
		prev_level = lvl;
		if (!item.link_up) begin
			return 1'b0;
		end
		if (bend_mode) begin
			m.status_byte = STATUS_BEND;
			m.data_first  = lvl[6:0];
			m.data_second = lvl[13:7];
		end else begin
			m.status_byte = STATUS_CC;
			m.data_first  = cc_num;
			m.data_second = lvl[6:0];
		end
		m.level = lvl;
		return 1'b1;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Every message transfer is compared with the oldest outstanding prediction.
	always @(posedge clk) begin : check_messages
		msg_t want;
		if (arst_n && msg_valid && !msg_stall) begin
			if (expected_msgs.size() == 0) begin
				$error("unexpected message: status %0h level %0d",
					msg_out.status_byte, msg_out.level);
				fail_count++;
			end else begin
				want = expected_msgs.pop_front();
				check_field("status_byte", 32'(want.status_byte), 32'(msg_out.status_byte));
				check_field("data_first", 32'(want.data_first), 32'(msg_out.data_first));
				check_field("data_second", 32'(want.data_second), 32'(msg_out.data_second));
				check_field("level", 32'(want.level), 32'(msg_out.level));
			end
		end
	end

	// The receiver changes its stall pattern now and then, and holds off on request.
	always @(posedge clk) begin : pace_receiver
		static int holds_served = 0;
		static int hold_left    = 0;
		static int stall_mode   = 0;
		static int mode_left    = 0;
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left    = HOLD_CYCLES;
			msg_stall   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left  = hold_left - 1;
			msg_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(16, 128);
			end else begin
				mode_left = mode_left - 1;
			end
			case (stall_mode)
				0: msg_stall <= 1'b0;
				1: msg_stall <= 1'($urandom_range(0, 1));
				default: msg_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// After each transfer the sender either carries on with its burst or takes a gap.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if ($urandom_range(0, 15) == 0) begin
				gap = $urandom_range(20, 40);
			end
			if (gap != 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// Offers one tick, waits for its transfer and records the predicted message.
	task automatic send_tick(logic [ELAPSED_W-1:0] elapsed, logic restart, logic link);
		tick_t item;
		msg_t  m;
		item       = '{elapsed_ms: elapsed, restart: restart, link_up: link};
		tick_valid <= 1'b1;
		tick_in    <= item;
		@(posedge clk);
		while (tick_stall) begin
			@(posedge clk);
		end
		if (predict_tick(item, m)) begin
			expected_msgs.push_back(m);
		end
		pace_sender();
	endtask

	// The sender stops until every predicted message has arrived and the block is idle.
	task automatic drain_results();
		tick_valid <= 1'b0;
		while (expected_msgs.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable afterwards.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_RUN_ENABLE:  run_on    = data[0];
			CFG_WAVE_SELECT: wave_sel  = data[1:0];
			CFG_PHASE_STEP:  step_reg  = data[STEP_W-1:0];
			CFG_DEPTH:       depth_reg = data[6:0];
			CFG_CC_NUMBER:   cc_num    = data[6:0];
			CFG_PITCH_MODE:  bend_mode = data[0];
			default: ;
		endcase
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		drain_results();
		write_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic run, logic [1:0] wave, logic [STEP_W-1:0] step,
		logic [6:0] amount, logic [6:0] cc, logic bend);
		drain_results();
		write_reg(CFG_RUN_ENABLE, CFG_W'(run));
		write_reg(CFG_WAVE_SELECT, CFG_W'(wave));
		write_reg(CFG_PHASE_STEP, CFG_W'(step));
		write_reg(CFG_DEPTH, CFG_W'(amount));
		write_reg(CFG_CC_NUMBER, CFG_W'(cc));
		write_reg(CFG_PITCH_MODE, CFG_W'(bend));
		cfg_we <= 1'b0;
	endtask

	// Register reset values: disabled ticks are dropped, then the default sine runs.
	task automatic test_reset_state();
		send_tick(16'hFFFF, 1'b1, 1'b1);
		set_reg(CFG_RUN_ENABLE, 26'd1);
		send_tick(16'd1000, 1'b0, 1'b1);
		send_tick(16'd250, 1'b0, 1'b1);
	endtask

	// With one phase unit per millisecond, a restart tick lands on an exact position.
	task automatic test_directed_shapes();
		logic [ELAPSED_W-1:0] sine_points[6] = '{16'd0, 16'd8192, 16'd16384, 16'd32768,
			16'd49152, 16'd65535};
		configure(1'b1, WAVE_SINE, 26'd65536, 7'd127, 7'd5, 1'b1);
		foreach (sine_points[i]) begin
			send_tick(sine_points[i], 1'b1, 1'b1);
		end
		set_reg(CFG_WAVE_SELECT, CFG_W'(WAVE_TRIANGLE));
		send_tick(16'd32768, 1'b1, 1'b1);
		send_tick(16'd32769, 1'b1, 1'b1);
		send_tick(16'd0, 1'b1, 1'b1);
		set_reg(CFG_WAVE_SELECT, CFG_W'(WAVE_SQUARE));
		send_tick(16'd32768, 1'b1, 1'b1);
		send_tick(16'd32769, 1'b1, 1'b1);
		set_reg(CFG_WAVE_SELECT, CFG_W'(WAVE_SAW));
		send_tick(16'd0, 1'b1, 1'b1);
		send_tick(16'd65535, 1'b1, 1'b1);
		// No movement gives an unchanged level and so no message.
		send_tick(16'd0, 1'b0, 1'b1);
		// With the link down the level is still remembered.
		send_tick(16'd100, 1'b1, 1'b0);
		send_tick(16'd0, 1'b0, 1'b1);
		// Switching to control change compares against the bend level.
		set_reg(CFG_PITCH_MODE, 26'd0);
		send_tick(16'd0, 1'b0, 1'b1);
	endtask

	// Unused indexes are ignored and wide data is cut to each register's width.
	task automatic test_register_writes();
		set_reg(CFG_SPARE_LOW, 26'h3FFFFFF);
		set_reg(CFG_SPARE_HIGH, 26'h3FFFFFF);
		send_tick(16'd3000, 1'b0, 1'b1);
		drain_results();
		write_reg(CFG_RUN_ENABLE, 26'h3FFFFFE);
		write_reg(CFG_DEPTH, 26'h3FFFFFF);
		write_reg(CFG_CC_NUMBER, 26'h3FFFF80);
		write_reg(CFG_WAVE_SELECT, 26'h3FFFFFD);
		write_reg(CFG_PITCH_MODE, 26'h2);
		write_reg(CFG_PHASE_STEP, 26'h3FFFFFF);
		cfg_we <= 1'b0;
		send_tick(16'd700, 1'b1, 1'b1);
		set_reg(CFG_RUN_ENABLE, 26'h3FFFFFF);
		send_tick(16'd1, 1'b0, 1'b1);
		send_tick(16'd977, 1'b0, 1'b1);
		send_tick(16'd12345, 1'b0, 1'b1);
	endtask

	// The receiver holds off while ticks keep coming, so the block must stall its input.
	task automatic test_backpressure();
		configure(1'b1, WAVE_SAW, 26'd65536, 7'd127, 7'd127, 1'b1);
		hold_requests++;
		for (int i = 0; i < 24; i++) begin
			send_tick(ELAPSED_W'($urandom_range(1, 4000)), 1'b0, 1'b1);
		end
		drain_results();
	endtask

	function automatic logic [ELAPSED_W-1:0] pick_elapsed();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'd1;
			3, 4: return ELAPSED_W'($urandom_range(1, 50));
			default: return ELAPSED_W'($urandom);
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 26'd1;
			3, 4: return STEP_W'($urandom_range(1, 1 << 20));
			default: return STEP_W'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_seven();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd127;
			default: return 7'($urandom);
		endcase
	endfunction

	// Settings change between phases; only ticks that the block acts on are counted.
	task automatic test_random_settings();
		int counted;
		int phase_no;
		int phase_len;
		counted  = 0;
		phase_no = 0;
		while (counted < RANDOM_TICKS) begin
			if (phase_no == 0) begin
				configure(1'b1, WAVE_SINE, '1, 7'd127, 7'd127, 1'b1);
			end else if (phase_no == 1) begin
				configure(1'b1, WAVE_TRIANGLE, '0, 7'd0, 7'd0, 1'b0);
			end else begin
				configure(($urandom_range(0, 11) != 0), 2'($urandom), pick_step(),
					pick_seven(), pick_seven(), 1'($urandom_range(0, 1)));
			end
			phase_len = run_on ? $urandom_range(40, 120) : 10;
			if (phase_no % 5 == 3) begin
				hold_requests++;
			end
			for (int i = 0; i < phase_len; i++) begin
				send_tick(pick_elapsed(), ($urandom_range(0, 15) == 0),
					($urandom_range(0, 7) != 0));
				if (run_on) begin
					counted++;
				end
			end
			phase_no++;
		end
	endtask

	initial begin
		run_on     = 1'b0;
		wave_sel   = WAVE_SINE;
		step_reg   = STEP_RESET;
		depth_reg  = DEPTH_RESET;
		cc_num     = CC_RESET;
		bend_mode  = 1'b0;
		phase      = '0;
		prev_level = LEVEL_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_shapes();
		test_register_writes();
		test_backpressure();
		test_random_settings();
		drain_results();
		if (expected_msgs.size() != 0) begin
			$error("%0d predicted messages never arrived", expected_msgs.size());
		end
		if (fail_count == 0 && expected_msgs.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#TIMEOUT_NS;
		$display("testbench: errors");
		$finish;
	end

endmodule
